/* sv/two_dim_parity_correct_unpack_defines.svh */
// Assertion macros used by the row memory and unpacker of the two-dimensional parity decoder.
`ifndef TWO_DIM_PARITY_CORRECT_UNPACK_DEFINES_SVH
`define TWO_DIM_PARITY_CORRECT_UNPACK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TDP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/tdp_pkg.sv */
// Shared constants and types for the two-dimensional parity decoder.
`default_nettype none

package tdp_pkg;

    // Data rows in one block; the row after them carries the column parity.
    localparam int unsigned ROWS = 7;
    localparam logic [2:0] CHECK_ROW = 3'd7;
    localparam logic [2:0] LAST_ROW = 3'd6;
    localparam logic [2:0] NEXT_TO_LAST_ROW = 3'd5;

    typedef logic [6:0] t_row_data;

    // Row write into the double-buffered row memory.
    typedef struct packed {
        logic       en;
        logic       bank;
        logic [2:0] row;
        t_row_data  data;
    } t_wr;

    // Per-block decode result handed to the unpacker.
    typedef struct packed {
        logic        err;
        logic        fix;
        logic        frame_end;
        logic [2:0]  fix_row;
        logic [2:0]  fix_col;
        logic [15:0] err_total;
        logic [15:0] fix_total;
    } t_job;

endpackage

`default_nettype wire

/* sv/two_dim_parity_correct_unpack.sv */
// Top level of the two-dimensional 8x8 parity decoder with correction and byte packing.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_rx_byte
//  out     | output    | o_out_valid / i_out_ready  | o_data_byte, o_block_error, o_block_fixed,
//          |           |                            | o_errors_total, o_fixed_total,
//          |           |                            | o_last_of_block, o_last_of_frame
//
// One received byte is taken per cycle. The check row of a block produces six or seven packed
// bytes, read out of the row memory one row per cycle, so one byte leaves per cycle at most.
// The row memory holds two banks, so a block is received while the previous one is unpacked; the
// input stalls only when the bank it needs is still being read, which is set by output stalls.
// Once the previous block is read out, the check row marks its bank busy, its rows are read and
// packed into the output register; with no bits left over, the first byte needs two rows.
// Reset is synchronous and active low; it clears all control state and the running totals.
`default_nettype none

module two_dim_parity_correct_unpack #(
    parameter int unsigned BLOCKS_PER_FRAME = 8,
    parameter int unsigned TOTAL_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_data_byte,
    output logic             o_block_error,
    output logic             o_block_fixed,
    output logic [15:0]      o_errors_total,
    output logic [15:0]      o_fixed_total,
    output logic             o_last_of_block,
    output logic             o_last_of_frame
);

    // Lowest set bit of a byte; zero when none is set.
    function automatic logic [2:0] low_index(input logic [7:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    logic                   r_wbank;
    logic [2:0]             r_row_count;
    logic [6:0]             r_mismatch;
    logic [7:0]             r_col_xor;
    logic [2:0]             r_block_count;
    logic [TOTAL_WIDTH-1:0] r_err_cnt;
    logic [TOTAL_WIDTH-1:0] r_fix_cnt;

    logic [TOTAL_WIDTH-1:0] n_err_cnt;
    logic [TOTAL_WIDTH-1:0] n_fix_cnt;
    logic [1:0]             busy;
    logic                   in_acc;
    logic                   is_check;
    logic [7:0]             diff;
    logic                   err;
    logic                   fix;
    logic                   frame_end;
    tdp_pkg::t_wr           wr;
    tdp_pkg::t_job          job;

    assign o_in_ready = !busy[r_wbank];
    assign in_acc     = i_in_valid && o_in_ready;
    assign is_check   = r_row_count == tdp_pkg::CHECK_ROW;

    // The check row closes the block: compare the column parity and decide on a correction.
    always_comb begin
        diff      = r_col_xor ^ i_rx_byte;
        err       = (r_mismatch != 7'd0) || (diff != 8'd0);
        fix       = ($countones(r_mismatch) == 1) && ($countones(diff) == 1);
        frame_end = r_block_count == 3'(BLOCKS_PER_FRAME - 1);
        n_err_cnt = (err && r_err_cnt != '1) ? r_err_cnt + TOTAL_WIDTH'(1) : r_err_cnt;
        n_fix_cnt = (fix && r_fix_cnt != '1) ? r_fix_cnt + TOTAL_WIDTH'(1) : r_fix_cnt;

        job.err       = err;
        job.fix       = fix;
        job.frame_end = frame_end;
        job.fix_row   = low_index({1'b0, r_mismatch});
        job.fix_col   = low_index(diff);
        job.err_total = 16'(32'(n_err_cnt));
        job.fix_total = 16'(32'(n_fix_cnt));

        wr.en   = in_acc && !is_check;
        wr.bank = r_wbank;
        wr.row  = r_row_count;
        wr.data = i_rx_byte[7:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wbank       <= 1'b0;
            r_row_count   <= 3'd0;
            r_mismatch    <= 7'd0;
            r_col_xor     <= 8'd0;
            r_block_count <= 3'd0;
            r_err_cnt     <= '0;
            r_fix_cnt     <= '0;
        end else if (in_acc) begin
            if (is_check) begin
                r_wbank       <= !r_wbank;
                r_row_count   <= 3'd0;
                r_mismatch    <= 7'd0;
                r_col_xor     <= 8'd0;
                r_block_count <= frame_end ? 3'd0 : r_block_count + 3'd1;
                r_err_cnt     <= n_err_cnt;
                r_fix_cnt     <= n_fix_cnt;
            end else begin
                r_row_count <= r_row_count + 3'd1;
                r_col_xor   <= r_col_xor ^ i_rx_byte;
                if (^i_rx_byte) begin
                    r_mismatch <= r_mismatch | (7'd1 << r_row_count);
                end
            end
        end
    end

    // Rows are stored per bank; the unpacker reads each finished block out in row order.
    tdp_unpack u_unpack (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr            (wr),
        .i_push          (in_acc && is_check),
        .i_push_bank     (r_wbank),
        .i_push_job      (job),
        .o_busy          (busy),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_data_byte     (o_data_byte),
        .o_block_error   (o_block_error),
        .o_block_fixed   (o_block_fixed),
        .o_errors_total  (o_errors_total),
        .o_fixed_total   (o_fixed_total),
        .o_last_of_block (o_last_of_block),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

`default_nettype wire

/* sv/tdp_unpack.sv */
// Row memory, single-bit correction on read-out and MSB-first byte packing.
`default_nettype none
`include "two_dim_parity_correct_unpack_defines.svh"

module tdp_unpack (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tdp_pkg::t_wr  i_wr,
    input  wire logic          i_push,
    input  wire logic          i_push_bank,
    input  wire tdp_pkg::t_job i_push_job,
    output logic [1:0]         o_busy,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [7:0]         o_data_byte,
    output logic               o_block_error,
    output logic               o_block_fixed,
    output logic [15:0]        o_errors_total,
    output logic [15:0]        o_fixed_total,
    output logic               o_last_of_block,
    output logic               o_last_of_frame
);

    tdp_pkg::t_row_data r_mem [2][tdp_pkg::ROWS];

    logic [1:0]         r_busy;
    tdp_pkg::t_job      r_job [2];
    logic               r_ubank;
    logic [2:0]         r_urow;

    logic               r_rd_valid;
    logic [2:0]         r_rd_row;
    tdp_pkg::t_job      r_rd_job;
    tdp_pkg::t_row_data r_rd_data;

    logic [6:0]         r_pack_bits;
    logic [2:0]         r_pack_fill;

    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_err;
    logic               r_out_fix;
    logic [15:0]        r_out_err_total;
    logic [15:0]        r_out_fix_total;
    logic               r_out_last_block;
    logic               r_out_last_frame;

    logic               out_free;
    logic               emit;
    logic               consume;
    logic               issue;
    logic               last;
    logic [2:0]         shift;
    logic [6:0]         mask;
    logic [13:0]        value;
    tdp_pkg::t_row_data row_fixed;
    logic [7:0]         n_byte;
    logic [6:0]         n_pack_bits;
    logic [2:0]         n_pack_fill;
    logic [1:0]         n_busy;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.bank][i_wr.row] <= i_wr.data;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_ubank][r_urow];
        end
    end

    // Apply the correction as the row leaves the memory, then pack it.
    always_comb begin
        row_fixed = r_rd_data;
        if (r_rd_job.fix && r_rd_row == r_rd_job.fix_row && r_rd_job.fix_col != 3'd0) begin
            row_fixed = r_rd_data ^ (7'd1 << (r_rd_job.fix_col - 3'd1));
        end
        value       = {r_pack_bits, row_fixed};
        emit        = r_pack_fill != 3'd0;
        shift       = r_pack_fill - 3'd1;
        mask        = ~(7'h7F << shift);
        n_byte      = 8'(value >> shift);
        n_pack_bits = emit ? (row_fixed & mask) : row_fixed;
        n_pack_fill = emit ? shift : 3'd7;
        last        = emit && (r_rd_row == tdp_pkg::LAST_ROW ||
                               (r_rd_row == tdp_pkg::NEXT_TO_LAST_ROW && r_pack_fill == 3'd1));
        out_free    = !r_out_valid || i_out_ready;
        consume     = r_rd_valid && (!emit || out_free);
        issue       = r_busy[r_ubank] && (!r_rd_valid || consume);

        // A handed-over block marks its bank busy; issuing its final row frees the bank.
        n_busy = r_busy;
        if (i_push) begin
            n_busy[i_push_bank] = 1'b1;
        end
        if (issue && r_urow == tdp_pkg::LAST_ROW) begin
            n_busy[r_ubank] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 2'b00;
            r_ubank     <= 1'b0;
            r_urow      <= 3'd0;
            r_rd_valid  <= 1'b0;
            r_pack_bits <= 7'd0;
            r_pack_fill <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (issue) begin
                if (r_urow == tdp_pkg::LAST_ROW) begin
                    r_urow  <= 3'd0;
                    r_ubank <= !r_ubank;
                end else begin
                    r_urow <= r_urow + 3'd1;
                end
                r_rd_valid <= 1'b1;
            end else if (consume) begin
                r_rd_valid <= 1'b0;
            end
            if (consume) begin
                r_pack_bits <= n_pack_bits;
                r_pack_fill <= n_pack_fill;
            end
            if (consume && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_job[i_push_bank] <= i_push_job;
        end
        if (issue) begin
            r_rd_row <= r_urow;
            r_rd_job <= r_job[r_ubank];
        end
        if (consume && emit) begin
            r_out_byte       <= n_byte;
            r_out_err        <= r_rd_job.err;
            r_out_fix        <= r_rd_job.fix;
            r_out_err_total  <= r_rd_job.err_total;
            r_out_fix_total  <= r_rd_job.fix_total;
            r_out_last_block <= last;
            r_out_last_frame <= last && r_rd_job.frame_end;
        end
    end

    assign o_busy          = r_busy;
    assign o_out_valid     = r_out_valid;
    assign o_data_byte     = r_out_byte;
    assign o_block_error   = r_out_err;
    assign o_block_fixed   = r_out_fix;
    assign o_errors_total  = r_out_err_total;
    assign o_fixed_total   = r_out_fix_total;
    assign o_last_of_block = r_out_last_block;
    assign o_last_of_frame = r_out_last_frame;

    `TDP_ASSERT_IMPL(a_write_free_bank, i_clk, i_rst_n, i_wr.en, !r_busy[i_wr.bank], "row write into a bank still being unpacked")
    `TDP_ASSERT_IMPL(a_push_free_bank, i_clk, i_rst_n, i_push, !r_busy[i_push_bank], "block handed over into a busy bank")
    `TDP_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, r_out_valid && !i_out_ready, r_out_valid && $stable(r_out_byte), "output item changed while stalled")

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the two-dimensional parity decoder with correction and packing.
`timescale 1ns / 1ps

module tb;

    // The block is built with its default frame length and counter width.
    localparam int unsigned BLOCKS_PER_FRAME = 8;
    localparam int unsigned TOTAL_WIDTH = 16;
    localparam longint unsigned TOTAL_MAX = (64'd1 << TOTAL_WIDTH) - 64'd1;
    localparam int unsigned IDLE_PERCENT = 8;
    localparam int unsigned RANDOM_BLOCKS = 30;

    // Ways in which a block of eight received bytes is damaged before it is sent.
    typedef enum int unsigned {
        BLK_CLEAN,
        BLK_DATA_FLIP,
        BLK_PARITY_FLIP,
        BLK_CHECK_FLIP,
        BLK_MULTI_FLIP,
        BLK_NOISE,
        BLK_KINDS
    } t_blk_kind;

    // One received byte waiting to be sent; hold makes the sender wait for the output to drain.
    typedef struct {
        logic [7:0] value;
        bit         hold;
    } t_rx_item;

    // One packed output byte with the status that travels alongside it.
    typedef struct packed {
        logic [7:0]  data;
        logic        err;
        logic        fix;
        logic [15:0] err_total;
        logic [15:0] fix_total;
        logic        last_blk;
        logic        last_frm;
    } t_out_byte;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  data_byte;
    logic        block_error;
    logic        block_fixed;
    logic [15:0] errors_total;
    logic [15:0] fixed_total;
    logic        last_of_block;
    logic        last_of_frame;

    t_rx_item    rx_pending[$];
    t_out_byte   expected_bytes[$];
    t_rx_item    next_item;
    t_out_byte   got;
    t_out_byte   want;

    // Shadow of the decoder state, updated as each item is accepted.
    tdp_pkg::t_row_data shadow_rows [tdp_pkg::ROWS];
    logic [7:0]         shadow_row_bad;
    logic [7:0]         shadow_col_xor;
    int unsigned        shadow_row_idx;
    int unsigned        shadow_blk_idx;
    logic [6:0]         shadow_pack_bits;
    int unsigned        shadow_pack_fill;
    longint unsigned    shadow_err_blocks;
    longint unsigned    shadow_fix_blocks;

    int unsigned bytes_taken = 0;
    int unsigned bytes_checked = 0;
    int unsigned fail_count = 0;
    int unsigned kind_count [BLK_KINDS];

    two_dim_parity_correct_unpack #(
        .BLOCKS_PER_FRAME(BLOCKS_PER_FRAME),
        .TOTAL_WIDTH(TOTAL_WIDTH)
    ) u_top (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_rx_byte(rx_byte),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_data_byte(data_byte),
        .o_block_error(block_error),
        .o_block_fixed(block_fixed),
        .o_errors_total(errors_total),
        .o_fixed_total(fixed_total),
        .o_last_of_block(last_of_block),
        .o_last_of_frame(last_of_frame)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Applies one received byte to the shadow state. Rows 0 to 6 are stored and their parity tracked; the check
    // row closes the block, applies any single-bit correction and packs the 49 data bits.
    task automatic absorb_byte(input logic [7:0] b);
        logic [7:0]  diff;
        logic [7:0]  acc;
        int unsigned n_rows;
        int unsigned n_cols;
        int unsigned fix_row;
        int unsigned fix_col;
        int unsigned fill;
        int unsigned emitted;
        bit          blk_err;
        bit          blk_fix;
        bit          frame_end;
        t_out_byte   made [7];

        if (shadow_row_idx < tdp_pkg::ROWS) begin
            shadow_rows[shadow_row_idx] = b[7:1];
            if (^b) begin
                shadow_row_bad[shadow_row_idx] = 1'b1;
            end
            shadow_col_xor = shadow_col_xor ^ b;
            shadow_row_idx++;
            return;
        end

        diff = shadow_col_xor ^ b;
        n_rows = $countones(shadow_row_bad[6:0]);
        n_cols = $countones(diff);
        blk_err = (n_rows + n_cols) != 0;
        blk_fix = (n_rows == 1) && (n_cols == 1);

        if (blk_fix) begin
            fix_row = 0;
            fix_col = 0;
            for (int i = 7; i >= 0; i--) begin
                if (shadow_row_bad[i] && i < tdp_pkg::ROWS) begin
                    fix_row = i;
                end
                if (diff[i]) begin
                    fix_col = i;
                end
            end
            // A mismatch in the parity column flips no data bit, yet the block still counts
            // as corrected.
            if (fix_col >= 1) begin
                shadow_rows[fix_row][fix_col - 1] = ~shadow_rows[fix_row][fix_col - 1];
            end
        end
        if (blk_err && shadow_err_blocks < TOTAL_MAX) begin
            shadow_err_blocks++;
        end
        if (blk_fix && shadow_fix_blocks < TOTAL_MAX) begin
            shadow_fix_blocks++;
        end
        frame_end = (shadow_blk_idx + 1) >= BLOCKS_PER_FRAME;

        acc = {1'b0, shadow_pack_bits};
        fill = shadow_pack_fill;
        emitted = 0;
        for (int r = 0; r < tdp_pkg::ROWS; r++) begin
            for (int k = 6; k >= 0; k--) begin
                acc = {acc[6:0], shadow_rows[r][k]};
                fill++;
                if (fill == 8) begin
                    made[emitted] = '{data: acc, err: blk_err, fix: blk_fix,
                                      err_total: shadow_err_blocks[15:0],
                                      fix_total: shadow_fix_blocks[15:0],
                                      last_blk: 1'b0, last_frm: 1'b0};
                    emitted++;
                    acc = 8'h00;
                    fill = 0;
                end
            end
        end
        made[emitted - 1].last_blk = 1'b1;
        made[emitted - 1].last_frm = frame_end;
        for (int i = 0; i < emitted; i++) begin
            expected_bytes.push_back(made[i]);
        end

        shadow_pack_bits = acc[6:0];
        shadow_pack_fill = fill;
        shadow_row_bad = 8'h00;
        shadow_col_xor = 8'h00;
        shadow_row_idx = 0;
        shadow_blk_idx = frame_end ? 0 : shadow_blk_idx + 1;
    endtask

    function automatic void check_field(input string name, input longint unsigned want_v,
                                        input longint unsigned got_v);
        if (want_v != got_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    // Builds one block of eight coded bytes, damages it as the kind asks and queues it.
    // With extremes set, the rows alternate between all ones and all zeros.
    task automatic queue_block(input t_blk_kind kind, input int unsigned flip_row,
                               input int unsigned flip_bit, input bit extremes,
                               input bit hold);
        logic [7:0]         blk [8];
        tdp_pkg::t_row_data data;
        int unsigned        pos_a;
        int unsigned        pos_b;

        blk[7] = 8'h00;
        for (int r = 0; r < tdp_pkg::ROWS; r++) begin
            data = extremes ? ((r % 2 == 0) ? 7'h7F : 7'h00) : tdp_pkg::t_row_data'($urandom);
            blk[r] = {data, ^data};
            blk[7] = blk[7] ^ blk[r];
        end
        case (kind)
            BLK_DATA_FLIP: begin
                blk[flip_row][flip_bit] = ~blk[flip_row][flip_bit];
            end
            BLK_PARITY_FLIP: begin
                blk[flip_row][0] = ~blk[flip_row][0];
            end
            BLK_CHECK_FLIP: begin
                blk[7][flip_bit] = ~blk[7][flip_bit];
            end
            BLK_MULTI_FLIP: begin
                // Two distinct bits anywhere in the block, so at least one check disagrees.
                pos_a = $urandom_range(63);
                pos_b = (pos_a + $urandom_range(1, 63)) % 64;
                blk[pos_a / 8][pos_a % 8] = ~blk[pos_a / 8][pos_a % 8];
                blk[pos_b / 8][pos_b % 8] = ~blk[pos_b / 8][pos_b % 8];
            end
            BLK_NOISE: begin
                for (int r = 0; r < 8; r++) begin
                    blk[r] = 8'($urandom);
                end
            end
            default: begin
            end
        endcase
        for (int r = 0; r < 8; r++) begin
            rx_pending.push_back('{value: blk[r], hold: hold && (r == 0)});
        end
        kind_count[kind]++;
    endtask

    // Sender: presents queued items, idles at random outside a quiet stretch, and holds an
    // item marked for a drain until every expected byte has come out.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                absorb_byte(rx_byte);
                bytes_taken++;
            end
            if (!in_valid || in_ready) begin
                if (rx_pending.size() != 0
                    && !(rx_pending[0].hold && expected_bytes.size() != 0)
                    && ((bytes_taken >= 120 && bytes_taken < 200)
                        || $urandom_range(99) >= IDLE_PERCENT)) begin
                    next_item = rx_pending.pop_front();
                    in_valid <= 1'b1;
                    rx_byte <= next_item.value;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted byte against the oldest expectation and stalls at random
    // outside its own quiet stretch.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                got = '{data: data_byte, err: block_error, fix: block_fixed,
                        err_total: errors_total, fix_total: fixed_total,
                        last_blk: last_of_block, last_frm: last_of_frame};
                if (expected_bytes.size() == 0) begin
                    $error("output byte 0x%0h arrived with nothing expected", data_byte);
                    fail_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    check_field("data_byte", want.data, got.data);
                    check_field("block_error", want.err, got.err);
                    check_field("block_fixed", want.fix, got.fix);
                    check_field("errors_total", want.err_total, got.err_total);
                    check_field("fixed_total", want.fix_total, got.fix_total);
                    check_field("last_of_block", want.last_blk, got.last_blk);
                    check_field("last_of_frame", want.last_frm, got.last_frm);
                end
                bytes_checked++;
            end
            out_ready <= (bytes_checked >= 60 && bytes_checked < 140)
                         || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    initial begin
        t_blk_kind kind;

        shadow_row_bad = 8'h00;
        shadow_col_xor = 8'h00;
        shadow_row_idx = 0;
        shadow_blk_idx = 0;
        shadow_pack_bits = 7'h00;
        shadow_pack_fill = 0;
        shadow_err_blocks = 0;
        shadow_fix_blocks = 0;
        for (int i = 0; i < BLK_KINDS; i++) begin
            kind_count[i] = 0;
        end

        // Directed blocks: a clean block of all-ones and all-zeros rows, a single data bit
        // that gets corrected, and a single parity-column error that counts as corrected
        // without changing any data.
        queue_block(BLK_CLEAN, 0, 0, 1'b1, 1'b0);
        queue_block(BLK_DATA_FLIP, 3, 5, 1'b0, 1'b0);
        queue_block(BLK_PARITY_FLIP, 6, 0, 1'b0, 1'b0);

        // Random blocks: mostly coded blocks with at most a single damaged bit, the rest with
        // several damaged bits or plain noise. Two of them wait for the output to drain first.
        for (int n = 0; n < RANDOM_BLOCKS; n++) begin
            case ($urandom_range(9))
                0, 1, 2: kind = BLK_CLEAN;
                3, 4:    kind = BLK_DATA_FLIP;
                5:       kind = BLK_PARITY_FLIP;
                6:       kind = BLK_CHECK_FLIP;
                7, 8:    kind = BLK_MULTI_FLIP;
                default: kind = BLK_NOISE;
            endcase
            queue_block(kind, $urandom_range(tdp_pkg::ROWS - 1),
                        (kind == BLK_CHECK_FLIP) ? $urandom_range(7) : $urandom_range(1, 7),
                        1'b0, (n == 10) || (n == 24));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (rx_pending.size() != 0 || in_valid) begin
            @(posedge clk);
        end
        while (expected_bytes.size() != 0) begin
            @(posedge clk);
        end
        // Let any stray output surface before the verdict.
        repeat (16) @(posedge clk);

        $display("Sent %0d bytes in %0d blocks: %0d clean, %0d data-bit, %0d parity-bit,",
                 bytes_taken, bytes_taken / 8, kind_count[BLK_CLEAN],
                 kind_count[BLK_DATA_FLIP], kind_count[BLK_PARITY_FLIP]);
        $display("%0d check-row, %0d multi-bit, %0d noise; %0d bytes checked, totals %0d/%0d.",
                 kind_count[BLK_CHECK_FLIP], kind_count[BLK_MULTI_FLIP],
                 kind_count[BLK_NOISE], bytes_checked, shadow_err_blocks, shadow_fix_blocks);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: ends a run that hangs and reports it as a failure.
    initial begin
        #200000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
